// ----- sv/bcve_pkg.sv -----
// ============================================================================
// bcve_pkg
// Shared types and codes of the bounded control value enumerator.
// ============================================================================
`default_nettype none

package bcve_pkg;

    // Widths fixed by the interface
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned COUNT_W  = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_STEP    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET     = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_MIN = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_MAX = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINIMUM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIMUM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESENT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESENT  = 3'd5;

    // Reset value of active_bytes
    localparam logic [COUNT_W-1:0] ACTIVE_BYTES_RST = 4'd1;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [COUNT_W-1:0] active_bytes;
        logic [VALUE_W-1:0] initial_value;
        logic [VALUE_W-1:0] minimum_value;
        logic [VALUE_W-1:0] maximum_value;
        logic               minimum_present;
        logic               maximum_present;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/bcve_cfg.sv -----
// ============================================================================
// bcve_cfg
// Configuration register file, written through a write enable and index.
// ============================================================================
`default_nettype none

module bcve_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [bcve_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [bcve_pkg::VALUE_W-1:0]      wr_data,
    output bcve_pkg::cfg_t                         cfg
);

    bcve_pkg::cfg_t cfg_reg;
    bcve_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bcve_pkg::REG_ACTIVE_BYTES:
                    cfg_next.active_bytes = wr_data[bcve_pkg::COUNT_W-1:0];
                bcve_pkg::REG_INITIAL:     cfg_next.initial_value = wr_data;
                bcve_pkg::REG_MINIMUM:     cfg_next.minimum_value = wr_data;
                bcve_pkg::REG_MAXIMUM:     cfg_next.maximum_value = wr_data;
                bcve_pkg::REG_MIN_PRESENT: cfg_next.minimum_present = wr_data[0];
                bcve_pkg::REG_MAX_PRESENT: cfg_next.maximum_present = wr_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_bytes    <= bcve_pkg::ACTIVE_BYTES_RST;
            cfg_reg.initial_value   <= '0;
            cfg_reg.minimum_value   <= '0;
            cfg_reg.maximum_value   <= '0;
            cfg_reg.minimum_present <= 1'b0;
            cfg_reg.maximum_present <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/bcve_core.sv -----
// ============================================================================
// bcve_core
// Combinational operation logic: carry chain, range checks and loads.
// ============================================================================
`default_nettype none

module bcve_core
#(
    parameter int unsigned MAX_BYTES = 8
)
(
    input  wire bcve_pkg::cfg_t                  cfg,
    input  wire logic [bcve_pkg::OP_W-1:0]       opcode,
    input  wire logic [bcve_pkg::VALUE_W-1:0]    new_value,
    input  wire logic [MAX_BYTES*8-1:0]          cur_value,
    output logic                                 accepted,
    output logic [MAX_BYTES*8-1:0]               next_value
);

    localparam int unsigned W = MAX_BYTES * 8;
    localparam logic [bcve_pkg::COUNT_W-1:0] NMAX = bcve_pkg::COUNT_W'(MAX_BYTES);

    logic [bcve_pkg::COUNT_W-1:0] n;
    logic [MAX_BYTES-1:0]         en;
    logic [W-1:0]                 mask;
    logic [W-1:0]                 cur;
    logic [W-1:0]                 mx;
    logic [W-1:0]                 mn;
    logic [W-1:0]                 nv;
    logic [W-1:0]                 init;
    logic [W-1:0]                 wrap;
    logic [W-1:0]                 step_val;
    logic [MAX_BYTES-1:0]         ov;
    logic [MAX_BYTES:0]           carry;
    logic [MAX_BYTES-1:0]         byte_ok;
    logic                         set_ok;

    // Clamp the active byte count
    always_comb
    begin
        if (cfg.active_bytes == '0)
            n = 4'd1;
        else if (cfg.active_bytes > NMAX)
            n = NMAX;
        else
            n = cfg.active_bytes;
    end

    // Byte enables and masked operands
    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            en[i]         = bcve_pkg::COUNT_W'(i) < n;
            mask[8*i +: 8] = {8{en[i]}};
        end
    end

    assign cur  = cur_value & mask;
    assign mx   = (cfg.maximum_present ? cfg.maximum_value[W-1:0] : {W{1'b1}}) & mask;
    assign mn   = cfg.minimum_value[W-1:0] & mask;
    assign nv   = new_value[W-1:0] & mask;
    assign init = cfg.initial_value[W-1:0] & mask;
    assign wrap = cfg.minimum_present ? mn : init;

    // Step: per-digit overflow and ripple carry from byte 0
    always_comb
    begin
        carry[0] = 1'b1;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            ov[i]        = cur[8*i +: 8] >= mx[8*i +: 8];
            carry[i+1]   = carry[i] & ov[i];
            if (!carry[i])
                step_val[8*i +: 8] = cur[8*i +: 8];
            else if (ov[i])
                step_val[8*i +: 8] = wrap[8*i +: 8];
            else
                step_val[8*i +: 8] = cur[8*i +: 8] + 8'd1;
        end
    end

    // Set: range check of every active byte
    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            byte_ok[i] = !(cfg.minimum_present && (mn[8*i +: 8] > nv[8*i +: 8]))
                      && !(cfg.maximum_present && (mx[8*i +: 8] < nv[8*i +: 8]));
        end
        set_ok = &(byte_ok | ~en);
    end

    // Operation select
    always_comb
    begin
        accepted   = 1'b0;
        next_value = cur;
        case (opcode)
            bcve_pkg::OP_STEP:
            begin
                if (cur != mx)
                begin
                    if (carry[MAX_BYTES])
                    begin
                        // every digit wrapped: saturate at the maximum
                        next_value = mx;
                    end
                    else
                    begin
                        next_value = step_val & mask;
                        accepted   = 1'b1;
                    end
                end
            end
            bcve_pkg::OP_SET:
            begin
                if (set_ok)
                begin
                    next_value = nv;
                    accepted   = 1'b1;
                end
            end
            bcve_pkg::OP_LOAD_MIN:
            begin
                if (cfg.minimum_present && (cur != mn))
                begin
                    next_value = mn;
                    accepted   = 1'b1;
                end
            end
            bcve_pkg::OP_LOAD_MAX:
            begin
                if (cur != mx)
                begin
                    next_value = mx;
                    accepted   = 1'b1;
                end
            end
            bcve_pkg::OP_RESTORE:
            begin
                next_value = init;
                accepted   = 1'b1;
            end
            default:
            begin
                next_value = cur;
                accepted   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/bounded_control_value_enumerator.sv -----
// ============================================================================
// bounded_control_value_enumerator
// Mixed-radix control value counter with per-byte bounds.
// ============================================================================
// Each item (opcode, new_value) passes an input register and combinational
// operation logic, and its result (accepted, current_value) lands in an output
// register. The result is valid once the item has moved from the input register
// to the output register; one item is taken every clock while the output side
// keeps up, since the held control value is updated in the same cycle an item
// moves to the output register.
// Configuration writes are always ready and should only be issued while no
// item is in flight.
`default_nettype none

module bounded_control_value_enumerator
#(
    parameter int unsigned MAX_BYTES = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input items
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bcve_pkg::OP_W-1:0]         opcode,
    input  wire logic [bcve_pkg::VALUE_W-1:0]      new_value,
    // result items
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   accepted,
    output logic [bcve_pkg::VALUE_W-1:0]           current_value,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bcve_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bcve_pkg::VALUE_W-1:0]      cfg_data
);

    localparam int unsigned W = MAX_BYTES * 8;

    bcve_pkg::cfg_t                   cfg;
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [bcve_pkg::OP_W-1:0]        opcode_reg;
    logic [bcve_pkg::VALUE_W-1:0]     new_value_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             accepted_reg;
    logic [W-1:0]                     state_reg;
    logic                             core_accepted;
    logic [W-1:0]                     core_value;
    logic                             in_take;
    logic                             advance;

    // Configuration registers
    assign cfg_ready = 1'b1;

    bcve_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: an item advances when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Operation logic
    bcve_core #(.MAX_BYTES(MAX_BYTES)) u_core
    (
        .cfg        (cfg),
        .opcode     (opcode_reg),
        .new_value  (new_value_reg),
        .cur_value  (state_reg),
        .accepted   (core_accepted),
        .next_value (core_value)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= core_value;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg    <= opcode;
            new_value_reg <= new_value;
        end
        if (advance)
            accepted_reg <= core_accepted;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign current_value = bcve_pkg::VALUE_W'(state_reg);

endmodule

`default_nettype wire

// ----- dv/tb_bounded_control_value_enumerator.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_bounded_control_value_enumerator
// Self-checking bench for the bounded mixed-radix control value counter.
// A directed table covers the reset state, the bound extremes, every defined opcode
// and the corner cases. Random phases then rewrite all registers and run
// mostly step items, with random gaps and output stalls outside calm phases. Every result is
// checked against the table or, where it gives none, a local model of the counter.
// ============================================================================

module tb_bounded_control_value_enumerator;

    // Opcodes with no operation behind them
    localparam logic [bcve_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [bcve_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;
    // Register index with no register behind it
    localparam logic [bcve_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_TAIL  = 4;
    localparam int IDLE_LIMIT  = 2000;

    // DUT ports
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [bcve_pkg::OP_W-1:0]      opcode = '0;
    logic [bcve_pkg::VALUE_W-1:0]   new_value = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           accepted;
    logic [bcve_pkg::VALUE_W-1:0]   current_value;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bcve_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bcve_pkg::VALUE_W-1:0]   cfg_data = '0;

    bounded_control_value_enumerator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .new_value     (new_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .current_value (current_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Expected result of one item
    typedef struct {
        bit                           acc;
        logic [bcve_pkg::VALUE_W-1:0] value;
    } outcome_t;

    // One row of the directed table: a register write or an item
    typedef struct {
        bit                           is_reg;
        logic [bcve_pkg::OP_W-1:0]    code;
        logic [bcve_pkg::VALUE_W-1:0] data;
        bit                           typed;
        bit                           acc;
        logic [bcve_pkg::VALUE_W-1:0] value;
    } row_t;

    outcome_t pending_results[$];
    row_t     plan[$];

    // Local copy of the registers and the held value
    logic [bcve_pkg::COUNT_W-1:0] mdl_count;
    logic [bcve_pkg::VALUE_W-1:0] mdl_init;
    logic [bcve_pkg::VALUE_W-1:0] mdl_lo;
    logic [bcve_pkg::VALUE_W-1:0] mdl_hi;
    bit                           mdl_lo_on;
    bit                           mdl_hi_on;
    logic [bcve_pkg::VALUE_W-1:0] mdl_value;

    int  fails = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_taken = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;

    // Apply one item to the local counter and return its outcome
    function automatic outcome_t advance_control(logic [bcve_pkg::OP_W-1:0] op,
                                                 logic [bcve_pkg::VALUE_W-1:0] nv);
        int unsigned                  n;
        logic [bcve_pkg::VALUE_W-1:0] mask;
        logic [bcve_pkg::VALUE_W-1:0] cur;
        logic [bcve_pkg::VALUE_W-1:0] mx;
        logic [bcve_pkg::VALUE_W-1:0] mn;
        logic [bcve_pkg::VALUE_W-1:0] v;
        logic [8:0]                   bump;
        logic [7:0]                   wrap;
        bit                           done;
        bit                           ok;
        outcome_t                     res;
        n = (mdl_count == 0) ? 1 : ((mdl_count > 8) ? 8 : mdl_count);
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        cur = mdl_value & mask;
        mx = (mdl_hi_on ? mdl_hi : '1) & mask;
        mn = mdl_lo & mask;
        v = nv & mask;
        res.acc = 1'b0;
        case (op)
            bcve_pkg::OP_STEP:
            begin
                if (cur != mx)
                begin
                    done = 1'b0;
                    for (int i = 0; i < n && !done; i++)
                    begin
                        wrap = mdl_lo_on ? mn[8*i +: 8] : mdl_init[8*i +: 8];
                        bump = {1'b0, cur[8*i +: 8]} + 9'd1;
                        if (bump > {1'b0, mx[8*i +: 8]})
                            cur[8*i +: 8] = wrap;
                        else
                        begin
                            cur[8*i +: 8] = bump[7:0];
                            done = 1'b1;
                        end
                    end
                    // every digit overflowed: park at the bound
                    if (done)
                        res.acc = 1'b1;
                    else
                        cur = mx;
                end
            end
            bcve_pkg::OP_SET:
            begin
                ok = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    if (mdl_lo_on && mn[8*i +: 8] > v[8*i +: 8])
                        ok = 1'b0;
                    if (mdl_hi_on && mx[8*i +: 8] < v[8*i +: 8])
                        ok = 1'b0;
                end
                if (ok)
                begin
                    cur = v;
                    res.acc = 1'b1;
                end
            end
            bcve_pkg::OP_LOAD_MIN:
            begin
                if (mdl_lo_on && cur != mn)
                begin
                    cur = mn;
                    res.acc = 1'b1;
                end
            end
            bcve_pkg::OP_LOAD_MAX:
            begin
                if (cur != mx)
                begin
                    cur = mx;
                    res.acc = 1'b1;
                end
            end
            bcve_pkg::OP_RESTORE:
            begin
                cur = mdl_init & mask;
                res.acc = 1'b1;
            end
            default:
            begin
            end
        endcase
        mdl_value = cur & mask;
        res.value = mdl_value;
        return res;
    endfunction

    // Random value that passes the range check byte by byte where it can
    function automatic logic [bcve_pkg::VALUE_W-1:0] value_in_bounds();
        logic [bcve_pkg::VALUE_W-1:0] v;
        int unsigned                  lo;
        int unsigned                  hi;
        for (int i = 0; i < 8; i++)
        begin
            lo = mdl_lo_on ? mdl_lo[8*i +: 8] : 0;
            hi = mdl_hi_on ? mdl_hi[8*i +: 8] : 255;
            if (lo <= hi)
                v[8*i +: 8] = 8'($urandom_range(hi, lo));
            else
                v[8*i +: 8] = 8'($urandom);
        end
        return v;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void item_row(logic [bcve_pkg::OP_W-1:0] op,
                                     logic [bcve_pkg::VALUE_W-1:0] nv,
                                     bit typed = 1'b0, bit acc = 1'b0,
                                     logic [bcve_pkg::VALUE_W-1:0] value = '0);
        row_t r;
        r.is_reg = 1'b0;
        r.code = op;
        r.data = nv;
        r.typed = typed;
        r.acc = acc;
        r.value = value;
        plan.push_back(r);
    endfunction

    function automatic void reg_row(logic [bcve_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bcve_pkg::VALUE_W-1:0] data);
        row_t r;
        r.is_reg = 1'b1;
        r.code = idx;
        r.data = data;
        r.typed = 1'b0;
        r.acc = 1'b0;
        r.value = '0;
        plan.push_back(r);
    endfunction

    // Starts and ends at a falling edge; cfg_valid stays high for a following write
    task automatic write_reg(logic [bcve_pkg::CFG_IDX_W-1:0] idx,
                             logic [bcve_pkg::VALUE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bcve_pkg::REG_ACTIVE_BYTES: mdl_count = data[bcve_pkg::COUNT_W-1:0];
            bcve_pkg::REG_INITIAL:      mdl_init = data;
            bcve_pkg::REG_MINIMUM:      mdl_lo = data;
            bcve_pkg::REG_MAXIMUM:      mdl_hi = data;
            bcve_pkg::REG_MIN_PRESENT:  mdl_lo_on = data[0];
            bcve_pkg::REG_MAX_PRESENT:  mdl_hi_on = data[0];
            default:                    ;
        endcase
        @(negedge clk);
    endtask

    // Starts and ends at a falling edge; predicts at the accepting edge
    task automatic send_item(logic [bcve_pkg::OP_W-1:0] op,
                             logic [bcve_pkg::VALUE_W-1:0] nv,
                             bit typed, bit acc, logic [bcve_pkg::VALUE_W-1:0] value);
        int       gap;
        outcome_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        new_value <= nv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = advance_control(op, nv);
        if (typed)
        begin
            res.acc = acc;
            res.value = value;
        end
        pending_results.push_back(res);
        n_items++;
        @(negedge clk);
    endtask

    // Wait until every result is back, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    // New random setting of all registers, narrow digit ranges favored
    task automatic random_setup();
        logic [bcve_pkg::VALUE_W-1:0] lo;
        logic [bcve_pkg::VALUE_W-1:0] hi;
        logic [bcve_pkg::VALUE_W-1:0] init;
        logic [bcve_pkg::VALUE_W-1:0] cnt;
        int                           r;
        int                           b;
        bit                           wide;
        r = $urandom_range(0, 19);
        cnt = {$urandom, $urandom};
        if (r == 0)
            cnt[3:0] = 4'd0;
        else if (r == 1)
            cnt[3:0] = 4'($urandom_range(15, 9));
        else if (r < 4)
            cnt[3:0] = 4'd8;
        else
            cnt[3:0] = 4'($urandom_range(4, 1));
        wide = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < 8; i++)
        begin
            r = $urandom_range(0, 9);
            b = $urandom_range(0, 255);
            lo[8*i +: 8] = wide ? 8'd0 : 8'(b);
            if (wide)
                hi[8*i +: 8] = 8'hFF;
            else if (r < 6)
                hi[8*i +: 8] = 8'((b + $urandom_range(0, 4) > 255) ? 255
                                   : b + $urandom_range(0, 4));
            else
                hi[8*i +: 8] = 8'($urandom);
            if ($urandom_range(0, 3) == 0 || lo[8*i +: 8] > hi[8*i +: 8])
                init[8*i +: 8] = 8'($urandom);
            else
                init[8*i +: 8] = 8'($urandom_range(hi[8*i +: 8], lo[8*i +: 8]));
        end
        write_reg(bcve_pkg::REG_ACTIVE_BYTES, cnt);
        write_reg(bcve_pkg::REG_INITIAL, init);
        write_reg(bcve_pkg::REG_MINIMUM, lo);
        write_reg(bcve_pkg::REG_MAXIMUM, hi);
        write_reg(bcve_pkg::REG_MIN_PRESENT, {$urandom, $urandom});
        write_reg(bcve_pkg::REG_MAX_PRESENT, {$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Output stall: bursts of random length, none in calm phases
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (calm)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (r < 70)
            out_stall <= 1'b0;
        else
        begin
            stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            out_stall <= 1'b1;
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: accepted %0d value %h",
                       accepted, current_value);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.acc) n_taken++;
                if (accepted !== want.acc)
                begin
                    $error("accepted: expected %0d, got %0d", want.acc, accepted);
                    fails++;
                end
                if (current_value !== want.value)
                begin
                    $error("current_value: expected %h, got %h", want.value, current_value);
                    fails++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a handshake, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int                           r;
        bit                           last_item;
        logic [bcve_pkg::OP_W-1:0]    op;
        logic [bcve_pkg::VALUE_W-1:0] nv;

        mdl_count = bcve_pkg::ACTIVE_BYTES_RST;
        mdl_init  = '0;
        mdl_lo    = '0;
        mdl_hi    = '0;
        mdl_lo_on = 1'b0;
        mdl_hi_on = 1'b0;
        mdl_value = '0;

        // After reset: one byte, no bounds, so the digit runs 0..255
        item_row(bcve_pkg::OP_STEP, '0, 1, 1, 64'h01);
        item_row(bcve_pkg::OP_LOAD_MAX, '0, 1, 1, 64'hFF);
        item_row(bcve_pkg::OP_STEP, '1, 1, 0, 64'hFF);
        item_row(bcve_pkg::OP_LOAD_MIN, '0, 1, 0, 64'hFF);
        item_row(bcve_pkg::OP_RESTORE, '1, 1, 1, 64'h00);
        item_row(bcve_pkg::OP_SET, '1, 1, 1, 64'hFF);
        item_row(OP_UNDEF_LO, '0, 1, 0, 64'hFF);
        item_row(OP_UNDEF_HI, 64'hA5A5_5A5A_0F0F_F0F0, 1, 0, 64'hFF);
        // Eight bytes, both bounds present
        reg_row(bcve_pkg::REG_ACTIVE_BYTES, 64'd8);
        reg_row(bcve_pkg::REG_INITIAL, 64'h0807_0605_0403_0201);
        reg_row(bcve_pkg::REG_MINIMUM, 64'h1010_1010_1010_1010);
        reg_row(bcve_pkg::REG_MAXIMUM, 64'h2020_2020_2020_2020);
        reg_row(bcve_pkg::REG_MIN_PRESENT, 64'd1);
        reg_row(bcve_pkg::REG_MAX_PRESENT, 64'd1);
        item_row(bcve_pkg::OP_RESTORE, '0, 1, 1, 64'h0807_0605_0403_0201);
        item_row(bcve_pkg::OP_SET, 64'h1010_1010_1010_100F, 1, 0,
                 64'h0807_0605_0403_0201);
        item_row(bcve_pkg::OP_SET, 64'h2020_2020_2020_2020, 1, 1,
                 64'h2020_2020_2020_2020);
        item_row(bcve_pkg::OP_STEP, '0, 1, 0, 64'h2020_2020_2020_2020);
        item_row(bcve_pkg::OP_LOAD_MIN, '0, 1, 1, 64'h1010_1010_1010_1010);
        item_row(bcve_pkg::OP_STEP, '0, 1, 1, 64'h1010_1010_1010_1011);
        item_row(bcve_pkg::OP_LOAD_MIN, '0);
        item_row(bcve_pkg::OP_LOAD_MIN, '0, 1, 0, 64'h1010_1010_1010_1010);
        item_row(bcve_pkg::OP_SET, 64'h2120_2020_2020_2020, 1, 0,
                 64'h1010_1010_1010_1010);
        // Two bytes, initial above the bounds: every digit overflows
        reg_row(bcve_pkg::REG_ACTIVE_BYTES, 64'd2);
        reg_row(bcve_pkg::REG_MIN_PRESENT, 64'd0);
        reg_row(bcve_pkg::REG_MAXIMUM, 64'h0302);
        reg_row(bcve_pkg::REG_INITIAL, 64'hFFFF_FFFF_FFFF_0505);
        item_row(bcve_pkg::OP_RESTORE, '0, 1, 1, 64'h0505);
        item_row(bcve_pkg::OP_STEP, '0, 1, 0, 64'h0302);
        item_row(bcve_pkg::OP_STEP, '0, 1, 0, 64'h0302);
        // Out-of-range byte counts and a missing maximum
        reg_row(bcve_pkg::REG_ACTIVE_BYTES, 64'hFFFF_FFFF_FFFF_FFF0);
        reg_row(bcve_pkg::REG_MAX_PRESENT, 64'hFFFF_FFFF_FFFF_FFFE);
        reg_row(REG_UNUSED, '1);
        item_row(bcve_pkg::OP_LOAD_MAX, '0, 1, 1, 64'hFF);
        reg_row(bcve_pkg::REG_ACTIVE_BYTES, 64'h0F);
        item_row(bcve_pkg::OP_LOAD_MAX, '0, 1, 1, '1);
        item_row(bcve_pkg::OP_STEP, '0, 1, 0, '1);
        item_row(bcve_pkg::OP_SET, '0, 1, 1, '0);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        last_item = 1'b0;
        foreach (plan[k])
        begin
            if (plan[k].is_reg)
            begin
                if (last_item)
                    drain();
                write_reg(plan[k].code, plan[k].data);
                last_item = 1'b0;
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_item(plan[k].code, plan[k].data, plan[k].typed,
                          plan[k].acc, plan[k].value);
                last_item = 1'b1;
            end
        end

        // Random phases, each with a fresh register setting
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            random_setup();
            calm = (p % 4 == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                nv = {$urandom, $urandom};
                if (r < 58)
                    op = bcve_pkg::OP_STEP;
                else if (r < 70)
                begin
                    op = bcve_pkg::OP_SET;
                    nv = value_in_bounds();
                end
                else if (r < 76)
                    op = bcve_pkg::OP_SET;
                else if (r < 82)
                    op = bcve_pkg::OP_LOAD_MIN;
                else if (r < 88)
                    op = bcve_pkg::OP_LOAD_MAX;
                else if (r < 94)
                    op = bcve_pkg::OP_RESTORE;
                else
                    op = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
                send_item(op, nv, 1'b0, 1'b0, '0);
            end
        end

        calm = 1'b0;
        drain();
        repeat (10) @(negedge clk);

        $display("Ran %0d items through %0d random register settings plus the directed table.",
                 n_items, PHASES);
        $display("Checked %0d results, %0d of them with the accepted flag set.",
                 n_results, n_taken);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bcve_pkg.sv
sv/bcve_cfg.sv
sv/bcve_core.sv
sv/bounded_control_value_enumerator.sv
dv/tb_bounded_control_value_enumerator.sv
